/* sv/chr_pkg.sv */
// Package: constants, types and hash function for the consistent hash ring.
`timescale 1ns / 1ps
`default_nettype none

package chr_pkg;

    localparam int MAX_SERVERS = 1024;
    localparam int REPLICAS    = 2;
    localparam int NODE_DEPTH  = MAX_SERVERS * REPLICAS;
    localparam int SRV_AW      = $clog2(MAX_SERVERS);
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int NODE_CW     = NODE_AW + 1;
    localparam int SRV_CW      = SRV_AW + 1;
    localparam int TAG_W       = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;

    localparam logic [63:0] HASH_MUL = 64'h0000_0000_045d_9f3b;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DIST   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LIMIT   = 3'd1,
        ST_PRESENT = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    // label = (tag << 48) ^ id
    function automatic logic [63:0] make_label(input logic [47:0] id,
                                               input logic [TAG_W-1:0] tag);
        logic [63:0] t;
        t = 64'(tag) << 48;
        return t ^ {16'h0, id};
    endfunction

    // x ^ (x >> 16)
    function automatic logic [63:0] fold16(input logic [63:0] x);
        return x ^ (x >> 16);
    endfunction

endpackage

`default_nettype wire

/* sv/chr_mul.sv */
// Pipelined 64 x 27 multiply mod 2^64 by the hash constant, two stages.
`timescale 1ns / 1ps
`default_nettype none

module chr_mul
    import chr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [63:0] a,
    output logic      [63:0] p
);

    logic [63:0] lo_reg;
    logic [63:0] hi_reg;

    // Split into two 32 x 27 partial products, then combine.
    always_ff @(posedge clk)
    begin
        lo_reg <= 64'(a[31:0] * HASH_MUL[26:0]);
        hi_reg <= 64'(a[63:32] * HASH_MUL[26:0]) << 32;
    end

    always_ff @(posedge clk)
    begin
        p <= lo_reg + hi_reg;
    end

endmodule

`default_nettype wire

/* sv/consistent_hash_ring.sv */
// Top level of the consistent hash ring with its sequencer and memories.
//
// Usage: one transaction in on s_axis (command, address, port) gives one
// transaction out on m_axis (status, server address, server port).
// The user must write register server_limit through cfg_we/cfg_wdata only while idle;
// the block does not enforce this. One item is worked at a time; s_axis_tready is
// high only when idle. Distribute hashes, then runs a binary search of up to 12
// steps, each reading the node table and then comparing, and reads the owner
// before the result is registered.
// Add scans the packed server table, reading and comparing each registered
// server, then for each replica hashes, searches and shifts the upper node table
// up one entry at a time. Remove scans, then compacts the node table one
// entry at a time and moves the last server entry into the freed slot.
// Cost is set by the single-port memories.
// The result waits in the output register while m_axis_tready is low;
// the next item is then already accepted and works until its own result.
// Reset clears the node and server counts and sets server_limit to 4;
// memories hold no reset value, entries below the counts are valid.
`timescale 1ns / 1ps
`default_nettype none

module consistent_hash_ring
    import chr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] command, [33:2] address, [49:34] port, zero fill
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status, [34:3] server_address, [50:35] server_port, zero fill
    output logic      [55:0] m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_W, S_H1, S_H2, S_H3, S_BS_RD, S_BS_CMP,
        S_SH_RD, S_SH_WR, S_INS, S_RM_RD, S_RM_WR, S_DIST_RD, S_DONE
    } state_t;

    state_t               state_reg;
    logic [10:0]          limit_reg;
    logic [1:0]           cmd_reg;
    logic [47:0]          id_reg;
    logic [NODE_CW-1:0]   ncount_reg;
    logic [SRV_CW-1:0]    scount_reg;
    logic [SRV_CW-1:0]    sidx_reg;
    logic                 found_reg;
    logic [SRV_AW-1:0]    fslot_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [3:0]           hcnt_reg;
    logic [63:0]          h_reg;
    logic [NODE_CW-1:0]   lo_reg;
    logic [NODE_CW-1:0]   hi_reg;
    logic [NODE_CW-1:0]   r_reg;
    logic [NODE_CW-1:0]   w_reg;
    logic [2:0]           status_reg;
    logic                 ovalid_reg;
    logic [55:0]          odata_reg;

    // Memories
    logic [47:0]  sid_mem [MAX_SERVERS];
    logic [63:0]  nh_mem  [NODE_DEPTH];
    logic [47:0]  no_mem  [NODE_DEPTH];
    logic [47:0]  sid_rd;
    logic [63:0]  nh_rd;
    logic [47:0]  no_rd;
    logic         sid_we;
    logic [SRV_AW-1:0] sid_wa;
    logic [47:0]  sid_wd;
    logic [SRV_AW-1:0] sid_ra;
    logic         n_we;
    logic [NODE_AW-1:0] n_addr;
    logic [63:0]  nh_wd;
    logic [47:0]  no_wd;

    always_ff @(posedge clk)
    begin
        if (sid_we)
            sid_mem[sid_wa] <= sid_wd;
        sid_rd <= sid_mem[sid_ra];
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            nh_mem[n_addr] <= nh_wd;
            no_mem[n_addr] <= no_wd;
        end
        nh_rd <= nh_mem[n_addr];
        no_rd <= no_mem[n_addr];
    end

    // Hash pipeline: fold, multiply, fold, multiply, fold
    logic [63:0] mul_in;
    logic [63:0] mul_out;
    chr_mul u_mul (.clk(clk), .a(mul_in), .p(mul_out));

    logic [10:0] lim_eff;
    assign lim_eff = (limit_reg > 11'(MAX_SERVERS)) ? 11'(MAX_SERVERS) : limit_reg;

    logic [NODE_CW-1:0] mid;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    logic [47:0] in_id;
    assign in_id = {s_axis_tdata[33:2], 16'h0} ^ {32'h0, s_axis_tdata[49:34]};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    // Memory control
    always_comb
    begin
        sid_we = 1'b0;
        sid_wa = scount_reg[SRV_AW-1:0];
        sid_wd = id_reg;
        sid_ra = sidx_reg[SRV_AW-1:0];
        n_we   = 1'b0;
        n_addr = mid[NODE_AW-1:0];
        nh_wd  = h_reg;
        no_wd  = id_reg;
        mul_in = fold16((hcnt_reg < 4'd4) ? make_label(id_reg, tag_reg) : mul_out);
        case (state_reg)
            S_H1:     sid_we = (hcnt_reg == 4'd0) && (tag_reg == '0) && (cmd_reg == CMD_ADD);
            S_SH_RD:  n_addr = NODE_AW'(r_reg - 1'b1);
            S_SH_WR:
            begin
                n_addr = r_reg[NODE_AW-1:0];
                n_we   = 1'b1;
                nh_wd  = nh_rd;
                no_wd  = no_rd;
            end
            S_INS:
            begin
                n_addr = lo_reg[NODE_AW-1:0];
                n_we   = 1'b1;
            end
            S_RM_RD:
            begin
                n_addr = r_reg[NODE_AW-1:0];
                // last server entry (still on the read port) fills the freed slot
                sid_we = (r_reg >= ncount_reg);
                sid_wa = fslot_reg;
                sid_wd = sid_rd;
            end
            S_RM_WR:
            begin
                n_addr = w_reg[NODE_AW-1:0];
                n_we   = (no_rd != id_reg);
                nh_wd  = nh_rd;
                no_wd  = no_rd;
            end
            S_DIST_RD, S_DONE: n_addr = (lo_reg >= ncount_reg) ? '0 : lo_reg[NODE_AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            limit_reg  <= 11'd4;
            ncount_reg <= '0;
            scount_reg <= '0;
            ovalid_reg <= 1'b0;
            cmd_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (ovalid_reg && m_axis_tready && state_reg != S_DONE)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (s_axis_tvalid)
                    begin
                        cmd_reg       <= s_axis_tdata[1:0];
                        id_reg        <= in_id;
                        sidx_reg      <= '0;
                        found_reg     <= 1'b0;
                        tag_reg       <= '0;
                        hcnt_reg      <= '0;
                        case (cmd_t'(s_axis_tdata[1:0]))
                            CMD_ADD:
                                if (scount_reg >= SRV_CW'(lim_eff))
                                begin
                                    status_reg <= ST_LIMIT;
                                    state_reg  <= S_DONE;
                                end
                                else if (scount_reg == '0)
                                begin
                                    status_reg <= ST_OK;
                                    state_reg  <= S_H1;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    state_reg  <= S_SCAN;
                                end
                            CMD_REMOVE:
                                if (scount_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    state_reg  <= S_SCAN;
                                end
                            CMD_DIST:
                                if (ncount_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    state_reg  <= S_H1;
                                end
                            default:
                            begin
                                status_reg <= ST_OK;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                // Server table scan over the packed entries: issue read, compare next cycle
                S_SCAN:
                begin
                    state_reg <= S_SCAN_W;
                end
                S_SCAN_W:
                begin
                    if (sid_rd == id_reg && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        fslot_reg <= sidx_reg[SRV_AW-1:0];
                    end
                    if (sidx_reg == scount_reg - 1'b1)
                    begin
                        if (cmd_reg == CMD_ADD)
                        begin
                            if (found_reg || sid_rd == id_reg)
                            begin
                                status_reg <= ST_PRESENT;
                                state_reg  <= S_DONE;
                            end
                            else
                                state_reg <= S_H1;
                        end
                        else if (!(found_reg || sid_rd == id_reg))
                        begin
                            status_reg <= ST_ABSENT;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            r_reg     <= '0;
                            w_reg     <= '0;
                            state_reg <= S_RM_RD;
                        end
                    end
                    else
                    begin
                        sidx_reg  <= sidx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                // Hash: hcnt 0 feeds label, 4 feeds first product
                S_H1:
                begin
                    hcnt_reg <= hcnt_reg + 1'b1;
                    if (hcnt_reg == 4'd4)
                        state_reg <= S_H2;
                    if (hcnt_reg == 4'd0 && tag_reg == '0 && cmd_reg == CMD_ADD)
                        scount_reg <= scount_reg + 1'b1;
                end
                S_H2:
                begin
                    hcnt_reg <= hcnt_reg + 1'b1;
                    if (hcnt_reg == 4'd6)
                        state_reg <= S_H3;
                end
                S_H3:
                begin
                    h_reg     <= fold16(mul_out);
                    lo_reg    <= '0;
                    hi_reg    <= ncount_reg;
                    state_reg <= (ncount_reg == '0) ? S_INS : S_BS_RD;
                end
                // Binary search: read mid, compare
                S_BS_RD: state_reg <= S_BS_CMP;
                S_BS_CMP:
                begin
                    if (nh_rd < h_reg)
                        lo_reg <= mid + 1'b1;
                    else
                        hi_reg <= mid;
                    if ((nh_rd < h_reg) ? (mid + 1'b1 >= hi_reg) : (mid <= lo_reg))
                    begin
                        if (cmd_reg == CMD_DIST)
                            state_reg <= S_DIST_RD;
                        else
                        begin
                            r_reg     <= ncount_reg;
                            state_reg <= S_SH_RD;
                        end
                    end
                    else
                        state_reg <= S_BS_RD;
                end
                // Shift nodes above insert point up by one
                S_SH_RD:
                    state_reg <= (r_reg > lo_reg) ? S_SH_WR : S_INS;
                S_SH_WR:
                begin
                    r_reg     <= r_reg - 1'b1;
                    state_reg <= S_SH_RD;
                end
                S_INS:
                begin
                    ncount_reg <= ncount_reg + 1'b1;
                    if (tag_reg == TAG_W'(REPLICAS - 1))
                        state_reg <= S_DONE;
                    else
                    begin
                        tag_reg   <= tag_reg + 1'b1;
                        hcnt_reg  <= '0;
                        state_reg <= S_H1;
                    end
                end
                // Compaction of node table
                S_RM_RD:
                    if (r_reg >= ncount_reg)
                    begin
                        ncount_reg <= w_reg;
                        scount_reg <= scount_reg - 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else
                        state_reg <= S_RM_WR;
                S_RM_WR:
                begin
                    if (no_rd != id_reg)
                        w_reg <= w_reg + 1'b1;
                    r_reg     <= r_reg + 1'b1;
                    state_reg <= S_RM_RD;
                end
                S_DIST_RD:
                begin
                    state_reg <= S_DONE;
                end
                // Owner reads back as {address, port}; result packs port above address
                S_DONE:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        ovalid_reg <= 1'b1;
                        odata_reg  <= {5'h0,
                            (cmd_reg == CMD_DIST && status_reg == ST_OK)
                                ? {no_rd[15:0], no_rd[47:16]} : 48'h0,
                            status_reg};
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // Node count is twice the server count whenever the sequencer is idle
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> ncount_reg == NODE_CW'(scount_reg) * REPLICAS)
        else $error("node and server counts disagree");

    // A held result must not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Server count never passes the table size
    a_scnt: assert property (@(posedge clk) disable iff (!rst_n)
        scount_reg <= SRV_CW'(MAX_SERVERS))
        else $error("server count overflow");
`endif

endmodule

`default_nettype wire

/* tb/sv/chr_checker.sv */
// Checker for the consistent hash ring: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module chr_checker
    import chr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [55:0] m_axis_tdata,
    output int               fail_count,
    output int               pending
);

    // shadow ring
    logic [63:0] ring_hash[$];
    logic [47:0] ring_owner[$];
    logic [47:0] srv_ids[$];
    logic [10:0] limit_reg;
    logic [50:0] expected_results[$];

    function automatic logic [63:0] mix(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = ((x >> 16) ^ x) * 64'h45d9f3b;
        x = ((x >> 16) ^ x) * 64'h45d9f3b;
        return (x >> 16) ^ x;
    endfunction

    function automatic int first_at_or_above(input logic [63:0] h);
        int lo, hi, mid;
        lo = 0;
        hi = ring_hash.size();
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (ring_hash[mid] < h) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [50:0] predict(input logic [55:0] d);
        logic [1:0] cmd;
        logic [47:0] id;
        logic [63:0] h;
        logic [2:0] st;
        logic [47:0] own;
        int lim, p, found;
        cmd = d[1:0];
        id = {d[33:2], 16'h0} ^ {32'h0, d[49:34]};
        st = ST_OK;
        own = '0;
        found = -1;
        foreach (srv_ids[i]) if (srv_ids[i] == id) found = i;
        if (cmd == CMD_ADD) begin
            lim = (limit_reg > MAX_SERVERS) ? MAX_SERVERS : limit_reg;
            if (srv_ids.size() >= lim) st = ST_LIMIT;
            else if (found >= 0) st = ST_PRESENT;
            else begin
                for (int t = 0; t < REPLICAS; t++) begin
                    h = mix((64'(t) << 48) ^ {16'h0, id});
                    p = first_at_or_above(h);
                    ring_hash.insert(p, h);
                    ring_owner.insert(p, id);
                end
                srv_ids.insert(srv_ids.size(), id);
            end
        end else if (cmd == CMD_REMOVE) begin
            if (srv_ids.size() == 0) st = ST_EMPTY;
            else if (found < 0) st = ST_ABSENT;
            else begin
                for (int r = ring_owner.size() - 1; r >= 0; r--)
                    if (ring_owner[r] == id) begin
                        ring_owner.delete(r);
                        ring_hash.delete(r);
                    end
                srv_ids.delete(found);
            end
        end else if (cmd == CMD_DIST) begin
            if (ring_hash.size() == 0) st = ST_EMPTY;
            else begin
                p = first_at_or_above(mix({16'h0, id}));
                if (p >= ring_hash.size()) p = 0;
                own = ring_owner[p];
            end
        end
        return {own[15:0], own[47:16], st};
    endfunction

    assign pending = expected_results.size();

    // predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        logic [50:0] exp_r;
        if (!rst_n)
        begin
            limit_reg <= 11'd4;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we) limit_reg <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_results.insert(expected_results.size(), predict(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_axis_tdata[2:0] !== exp_r[2:0]
                        || m_axis_tdata[34:3] !== exp_r[34:3]
                        || m_axis_tdata[50:35] !== exp_r[50:35]
                        || m_axis_tdata[55:51] !== 5'd0)
                    begin
                        $display("%0t: mismatch expected st=%0d %h:%h actual st=%0d %h:%h",
                                 $time, exp_r[2:0], exp_r[34:3], exp_r[50:35],
                                 m_axis_tdata[2:0], m_axis_tdata[34:3],
                                 m_axis_tdata[50:35]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the consistent hash ring: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb
    import chr_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          hold_off;
    logic [47:0] known_srv[$];

    consistent_hash_ring dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    chr_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off) m_axis_tready <= 1'b0;
            else
            begin
                mode = $urandom_range(0, 3);
                if (mode == 0) m_axis_tready <= 1'b1;
                else m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [31:0] a, input logic [15:0] p);
        s_axis_tdata <= {6'd0, p, a, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic drain_and_set(input logic [10:0] lim);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4000) @(negedge clk);
        cfg_wdata <= lim;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random item, mostly well-formed against a pool of servers
    task automatic random_item();
        int k;
        logic [47:0] id;
        k = $urandom_range(0, 99);
        if (known_srv.size() == 0 || k < 15)
        begin
            id = 48'({$urandom, $urandom});
            if (known_srv.size() < 40) known_srv.insert(known_srv.size(), id);
            send(CMD_ADD, id[47:16], id[15:0]);
        end
        else if (k < 25)
        begin
            id = known_srv[$urandom_range(0, known_srv.size() - 1)];
            send(2'($urandom_range(0, 1)), id[47:16], id[15:0]);
        end
        else if (k < 30)
            send(CMD_NONE, $urandom, 16'($urandom));
        else if (k < 34)
            send(CMD_REMOVE, $urandom, 16'($urandom));
        else
            send(CMD_DIST, $urandom, 16'($urandom));
    endtask

    initial
    begin
        int burst;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        hold_off = 1'b0;
        idle_cycles = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty ring, reset limit, full and duplicate cases
        send(CMD_DIST, 32'h0, 16'h0);
        send(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send(CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF);
        send(CMD_ADD, 32'h0, 16'h0);
        send(CMD_ADD, 32'h0, 16'h0);
        send(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send(CMD_REMOVE, 32'h1234_5678, 16'h9ABC);
        send(CMD_DIST, 32'hFFFF_FFFF, 16'hFFFF);
        send(CMD_ADD, 32'hC0A8_0001, 16'd80);
        send(CMD_ADD, 32'h0A00_0001, 16'd443);
        send(CMD_ADD, 32'h0A00_0002, 16'd443);
        send(CMD_DIST, 32'h5555_5555, 16'hAAAA);
        send(CMD_DIST, 32'hAAAA_AAAA, 16'h5555);
        send(CMD_REMOVE, 32'h0, 16'h0);
        send(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send(CMD_REMOVE, 32'hC0A8_0001, 16'd80);
        send(CMD_REMOVE, 32'h0A00_0001, 16'd443);
        send(CMD_DIST, 32'h0, 16'h1);

        // limit zero, then limit above the maximum
        drain_and_set(11'd0);
        send(CMD_ADD, 32'h0101_0101, 16'h0101);
        drain_and_set(11'h7FF);

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
            repeat (600) @(negedge clk);
            repeat (6) send(CMD_DIST, $urandom, 16'($urandom));
        join_any
        hold_off = 1'b0;
        wait fork;

        // random phases over several limits
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 1) drain_and_set(11'd1024);
            if (ph == 2) drain_and_set(11'd8);
            if (ph == 3) drain_and_set(11'd3);
            for (int n = 0; n < 250; n += burst)
            begin
                burst = $urandom_range(1, 12);
                repeat (burst) random_item();
                if ($urandom_range(0, 2) == 0) gap();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
